// ----- rtl/mbfe_pkg.sv -----
package mbfe_pkg;

    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam int unsigned NUM_SEGS = 6;

    typedef enum logic [2:0] {
        PH_INIT,
        PH_SOL,
        PH_GT,
        PH_MATCH,
        PH_MID,
        PH_CLOSED,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        SEG_HDR,
        SEG_HELD,
        SEG_ESC,
        SEG_BYTE,
        SEG_CRLF,
        SEG_ERR
    } seg_t;

    // One request's worth of output, as a set of segments emitted in enum order.
    typedef struct packed {
        logic       hdr;
        logic [2:0] held_cnt;
        logic       esc;
        logic       byte_en;
        logic [7:0] data;
        logic [1:0] crlf_cnt;
        logic       err;
    } desc_t;

    function automatic logic [7:0] from_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h46;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h6F;
            3'd3:    c = 8'h6D;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/mbfe_front.sv -----
module mbfe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  logic          func,
    input  logic [7:0]    data_byte,
    input  logic          q_full,
    output logic          push,
    output mbfe_pkg::desc_t push_desc
);
    import mbfe_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [2:0] mc_reg;
    logic [2:0] mc_next;
    logic       accept;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INIT;
            mc_reg    <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            mc_reg    <= mc_next;
        end
    end

    always_comb
    begin
        desc_t  d;
        phase_t p;
        logic   live;
        d          = '0;
        d.data     = data_byte;
        p          = phase_reg;
        phase_next = phase_reg;
        mc_next    = mc_reg;
        live = (phase_reg == PH_INIT) || (phase_reg == PH_SOL) || (phase_reg == PH_GT) ||
               (phase_reg == PH_MATCH) || (phase_reg == PH_MID);
        if (accept)
        begin
            if (!live)
            begin
                d.err      = 1'b1;
                phase_next = PH_ERROR;
                mc_next    = 3'd0;
            end
            else if (func)
            begin
                d.held_cnt = (phase_reg == PH_MATCH) ? mc_reg : 3'd0;
                d.crlf_cnt = (phase_reg == PH_GT || phase_reg == PH_MID ||
                              phase_reg == PH_MATCH) ? 2'd2 : 2'd1;
                phase_next = PH_CLOSED;
                mc_next    = 3'd0;
            end
            else
            begin
                d.hdr = (phase_reg == PH_INIT);
                if (phase_reg == PH_INIT)
                begin
                    p = PH_SOL;
                end
                case (p)
                    PH_SOL, PH_GT:
                    begin
                        if (data_byte == CH_GT)
                        begin
                            d.byte_en  = 1'b1;
                            phase_next = PH_GT;
                        end
                        else if (data_byte == from_char(3'd0))
                        begin
                            mc_next    = 3'd1;
                            phase_next = PH_MATCH;
                        end
                        else
                        begin
                            d.byte_en  = 1'b1;
                            phase_next = (data_byte == CH_NL) ? PH_SOL : PH_MID;
                        end
                    end
                    PH_MATCH:
                    begin
                        if (data_byte == from_char(mc_reg))
                        begin
                            if (mc_reg == 3'd4)
                            begin
                                d.esc      = 1'b1;
                                mc_next    = 3'd0;
                                phase_next = PH_MID;
                            end
                            else
                            begin
                                mc_next = mc_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            d.held_cnt = mc_reg;
                            d.byte_en  = 1'b1;
                            mc_next    = 3'd0;
                            phase_next = (data_byte == CH_NL) ? PH_SOL : PH_MID;
                        end
                    end
                    default:
                    begin
                        d.byte_en  = 1'b1;
                        phase_next = (data_byte == CH_NL) ? PH_SOL : PH_MID;
                    end
                endcase
            end
        end
        push_desc = d;
        push = accept && (d.hdr || (d.held_cnt != 3'd0) || d.esc || d.byte_en ||
                          (d.crlf_cnt != 2'd0) || d.err);
    end

endmodule

// ----- rtl/mbfe_queue.sv -----
module mbfe_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbfe_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output mbfe_pkg::desc_t head_desc
);
    import mbfe_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    desc_t         mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- rtl/mbfe_back.sv -----
module mbfe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  mbfe_pkg::desc_t head_desc,
    output logic            pop,
    output logic            res_valid,
    input  logic            res_stall,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic            error
);
    import mbfe_pkg::*;

    function automatic logic [3:0] first_seg(input logic [NUM_SEGS-1:0] mask,
                                             input logic [2:0] from);
        logic       found;
        logic [2:0] idx;
        found = 1'b0;
        idx   = 3'd0;
        for (int i = 0; i < NUM_SEGS; i++)
        begin
            if (!found && mask[i] && (3'(i) >= from))
            begin
                found = 1'b1;
                idx   = 3'(i);
            end
        end
        return {found, idx};
    endfunction

    logic                busy_reg;
    logic                busy_next;
    seg_t                seg_reg;
    seg_t                seg_next;
    logic [2:0]          idx_reg;
    logic [2:0]          idx_next;
    logic                res_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                last_reg;
    logic                error_reg;
    logic                load;
    logic [NUM_SEGS-1:0] mask;
    seg_t                cur_seg;
    logic [2:0]          cur_idx;
    logic [2:0]          end_idx;
    logic [3:0]          nxt;
    logic                done;
    logic [7:0]          cur_byte;

    assign load = head_valid && (!res_valid_reg || !res_stall);
    assign pop  = load && done;

    always_comb
    begin
        logic [3:0] f;
        mask[SEG_HDR]  = head_desc.hdr;
        mask[SEG_HELD] = (head_desc.held_cnt != 3'd0);
        mask[SEG_ESC]  = head_desc.esc;
        mask[SEG_BYTE] = head_desc.byte_en;
        mask[SEG_CRLF] = (head_desc.crlf_cnt != 2'd0);
        mask[SEG_ERR]  = head_desc.err;
        f       = first_seg(mask, 3'd0);
        cur_seg = busy_reg ? seg_reg : seg_t'(f[2:0]);
        cur_idx = busy_reg ? idx_reg : 3'd0;
        case (cur_seg)
            SEG_HDR:  end_idx = 3'd6;
            SEG_HELD: end_idx = head_desc.held_cnt - 3'd1;
            SEG_ESC:  end_idx = 3'd5;
            SEG_CRLF: end_idx = (head_desc.crlf_cnt == 2'd2) ? 3'd3 : 3'd1;
            default:  end_idx = 3'd0;
        endcase
        case (cur_seg)
            SEG_HDR:
            begin
                if (cur_idx == 3'd5)
                begin
                    cur_byte = CH_CR;
                end
                else if (cur_idx == 3'd6)
                begin
                    cur_byte = CH_NL;
                end
                else
                begin
                    cur_byte = from_char(cur_idx);
                end
            end
            SEG_HELD: cur_byte = from_char(cur_idx);
            SEG_ESC:  cur_byte = (cur_idx == 3'd0) ? CH_GT : from_char(cur_idx - 3'd1);
            SEG_BYTE: cur_byte = head_desc.data;
            SEG_CRLF: cur_byte = cur_idx[0] ? CH_NL : CH_CR;
            default:  cur_byte = 8'h00;
        endcase
        nxt  = first_seg(mask, 3'(cur_seg) + 3'd1);
        done = (cur_idx == end_idx) && !nxt[3];

        busy_next = busy_reg;
        seg_next  = seg_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            if (cur_idx != end_idx)
            begin
                busy_next = 1'b1;
                seg_next  = cur_seg;
                idx_next  = cur_idx + 3'd1;
            end
            else if (nxt[3])
            begin
                busy_next = 1'b1;
                seg_next  = seg_t'(nxt[2:0]);
                idx_next  = 3'd0;
            end
            else
            begin
                busy_next = 1'b0;
                seg_next  = SEG_HDR;
                idx_next  = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seg_reg       <= SEG_HDR;
            idx_reg       <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            seg_reg  <= seg_next;
            idx_reg  <= idx_next;
            if (load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= done;
            error_reg    <= (cur_seg == SEG_ERR);
        end
    end

    assign res_valid = res_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

// ----- rtl/mbox_from_line_escaper.sv -----
// A request's first result passes the queue and then the output register before it can be taken.
// Throughput: one request per cycle while each request yields at most one result and res_stall is low.
// The output stage emits one result per cycle unless stalled and pops a request with its last result.
// A DEPTH-entry queue (four by default) between classifier and output stage absorbs these bursts.
// Reset is asynchronous and active low; it empties the queue and returns to header-not-sent.
module mbox_from_line_escaper #(
    parameter int unsigned DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       func,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       error
);
    import mbfe_pkg::*;

    logic  q_full;
    logic  push;
    desc_t push_desc;
    logic  pop;
    logic  head_valid;
    desc_t head_desc;

    mbfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    mbfe_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    mbfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

endmodule

// ----- rtl/mbfe_checker.sv -----
module mbfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] out_byte,
    input logic       last,
    input logic       error
);

    logic closed_reg;

    // Once an error result has been delivered, the stream stays in error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
        end
        else if (res_valid && !res_stall && error)
        begin
            closed_reg <= 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(out_byte) && $stable(last) && $stable(error))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error |-> last && (out_byte == 8'h00))
    else $error("error result is not a single zero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg && res_valid |-> error)
    else $error("normal result after an error result");

endmodule

bind mbox_from_line_escaper mbfe_checker u_checker (.*);
